[rtl/expiring_name_cache_defines.svh]
// Assertion macros for the expiring name cache.
// Included by the top level; no other dependencies.
`ifndef EXPIRING_NAME_CACHE_DEFINES_SVH
`define EXPIRING_NAME_CACHE_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent in the same cycle implies consequent
`define ENC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
// antecedent implies consequent in the next cycle
`define ENC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define ENC_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define ENC_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif
`endif

[rtl/enc_pkg.sv]
// Shared constants and types for the expiring name cache.
// No dependencies.
package enc_pkg;
	localparam int ENTRIES        = 1024;
	localparam int NAME_BYTES     = 32;
	localparam int NAME_WORDS     = (NAME_BYTES + 7) / 8;
	localparam int IDX_W          = $clog2(ENTRIES);
	localparam int WORD_W         = 64;
	localparam int TIME_W         = 32;
	localparam int ADDR_W         = 32;
	localparam int LIFE_W         = 16;
	localparam int WIDX_W         = 2;
	localparam int SLOT_W         = 10;
	localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd900;
	localparam logic MODE_LOOKUP  = 1'b0;
	localparam logic MODE_INSERT  = 1'b1;

	// control shared by every cell of the compare chain
	typedef struct packed {
		logic             buf_clr;
		logic [IDX_W-1:0] rd_addr;
		logic             mem_we;
		logic [IDX_W-1:0] mem_waddr;
	} cell_ctrl_t;
endpackage

[rtl/enc_cell.sv]
// One name-word cell: buffer word, name bank and compare stage.
// Depends on enc_pkg.
module enc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  enc_pkg::cell_ctrl_t        ctrl,
	input  logic                       buf_we,
	input  logic [enc_pkg::WORD_W-1:0] buf_wdata,
	input  logic                       match_in,
	output logic                       match_out
);
	logic [enc_pkg::WORD_W-1:0] buf_q;
	logic [enc_pkg::WORD_W-1:0] bank [enc_pkg::ENTRIES];
	logic [enc_pkg::WORD_W-1:0] rd_q;

	// hold this cell's word of the pending name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
		end else if (ctrl.buf_clr) begin
			buf_q <= '0;
		end else if (buf_we) begin
			buf_q <= buf_wdata;
		end
	end

	// name bank: one write, one registered read
	always_ff @(posedge clk) begin
		if (ctrl.mem_we) begin
			bank[ctrl.mem_waddr] <= buf_q;
		end
		rd_q <= bank[ctrl.rd_addr];
	end

	// pass the match on to the next cell
	assign match_out = match_in & (rd_q == buf_q);
endmodule

[rtl/expiring_name_cache.sv]
// Top level of the expiring name cache: scan control, expiry and address stores.
// Depends on enc_pkg, enc_cell and expiring_name_cache_defines.svh.
//
// channel  dir  fields
// s_axis   in   tuser=mode, tlast=last_word, tdata=name_word,word_index,now,address
// m_axis   out  tdata=hit,address_out,slot,evicted_live
// cfg      in   lifetime_seconds
//
// A non-last word is only stored in its cell's buffer. A last word scans the entries
// one per cycle through the cell chain and the expiry memory.
// After reset every entry of the expiry memory is cleared; no word is taken until then.
// A stalled result holds the block in its final step until it is taken.
`include "expiring_name_cache_defines.svh"
module expiring_name_cache (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [135:0]  s_tdata,  // name_word[63:0], word_index[65:64], now[97:66],
	                                // address_in[129:98], zero fill
	input  logic          s_tuser,  // mode
	input  logic          s_tlast,  // last_word
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [47:0]   m_tdata,  // hit[0], address_out[32:1], slot[42:33],
	                                // evicted_live[43], zero fill
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [15:0]   cfg_data
);
	localparam int IW = enc_pkg::IDX_W;
	localparam int NW = enc_pkg::NAME_WORDS;
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_WRITE = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;
	localparam logic [IW:0] ENTRIES_C = (IW+1)'(enc_pkg::ENTRIES);
	localparam logic [IW-1:0] LAST_C = IW'(enc_pkg::ENTRIES - 1);

	logic [2:0]  state_q;
	logic [IW:0] cnt_q;
	logic        valid_s1;
	logic [IW-1:0] idx_s1;
	logic [enc_pkg::LIFE_W-1:0] life_q;
	logic        mode_q;
	logic [31:0] now_q, addr_in_q, exp_new_q;
	logic        hit_q, evict_q;
	logic [31:0] aout_q;
	logic [IW-1:0] slot_q;
	logic        m_tvalid_q;
	logic [47:0] m_tdata_q;
	logic [31:0] exp_mem [enc_pkg::ENTRIES];
	logic [31:0] adr_mem [enc_pkg::ENTRIES];
	logic [31:0] exp_rd_q, adr_rd_q;
	logic [NW:0] match;
	enc_pkg::cell_ctrl_t ctrl;
	logic        accept, live, stop_hit, stop_free, scan_end, out_free;
	logic [32:0] sum;
	logic [1:0]  widx;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign widx      = s_tdata[65:64];
	assign sum       = {1'b0, s_tdata[97:66]} + {17'd0, life_q};
	assign live      = exp_rd_q > now_q;
	assign stop_hit  = valid_s1 && (mode_q == enc_pkg::MODE_LOOKUP) && live && match[NW];
	assign stop_free = valid_s1 && (mode_q == enc_pkg::MODE_INSERT) && !live;
	assign scan_end  = valid_s1 && (idx_s1 == LAST_C);
	assign out_free  = !m_tvalid_q || m_tready;

	assign ctrl.buf_clr   = (state_q == ST_DONE) && out_free;
	assign ctrl.rd_addr   = cnt_q[IW-1:0];
	assign ctrl.mem_we    = (state_q == ST_WRITE);
	assign ctrl.mem_waddr = slot_q;

	// compare chain, one cell per name word
	assign match[0] = 1'b1;
	for (genvar k = 0; k < NW; k++) begin : g_cell
		enc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.buf_we    (accept && (widx == 2'(k))),
			.buf_wdata (s_tdata[63:0]),
			.match_in  (match[k]),
			.match_out (match[k+1])
		);
	end

	// lifetime register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			life_q <= enc_pkg::LIFETIME_RESET;
		end else if (cfg_valid) begin
			life_q <= cfg_data;
		end
	end

	// expiry and address stores: clear pass (expiry only), insert write, registered read
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR) begin
			exp_mem[cnt_q[IW-1:0]] <= '0;
		end else if (state_q == ST_WRITE) begin
			exp_mem[slot_q] <= exp_new_q;
			adr_mem[slot_q] <= addr_in_q;
		end
		exp_rd_q <= exp_mem[cnt_q[IW-1:0]];
		adr_rd_q <= adr_mem[cnt_q[IW-1:0]];
	end

	// capture operation operands on the last word
	always_ff @(posedge clk) begin
		if (accept && s_tlast) begin
			mode_q    <= s_tuser;
			now_q     <= s_tdata[97:66];
			addr_in_q <= s_tdata[129:98];
			exp_new_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
	end

	// sequencer: clear, scan, write, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			hit_q    <= 1'b0;
			evict_q  <= 1'b0;
			aout_q   <= '0;
			slot_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q[IW-1:0] == LAST_C) begin
						state_q <= ST_IDLE;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept && s_tlast) begin
						state_q  <= ST_SCAN;
						cnt_q    <= '0;
						valid_s1 <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (stop_hit) begin
						hit_q    <= 1'b1;
						aout_q   <= adr_rd_q;
						slot_q   <= idx_s1;
						evict_q  <= 1'b0;
						valid_s1 <= 1'b0;
						state_q  <= ST_DONE;
					end else if (stop_free) begin
						hit_q    <= 1'b0;
						aout_q   <= '0;
						slot_q   <= idx_s1;
						evict_q  <= 1'b0;
						valid_s1 <= 1'b0;
						state_q  <= ST_WRITE;
					end else if (scan_end) begin
						hit_q    <= 1'b0;
						aout_q   <= '0;
						valid_s1 <= 1'b0;
						if (mode_q == enc_pkg::MODE_INSERT) begin
							slot_q  <= now_q[IW-1:0];
							evict_q <= 1'b1;
							state_q <= ST_WRITE;
						end else begin
							slot_q  <= '0;
							evict_q <= 1'b0;
							state_q <= ST_DONE;
						end
					end else begin
						valid_s1 <= (cnt_q < ENTRIES_C);
						idx_s1   <= cnt_q[IW-1:0];
						if (cnt_q < ENTRIES_C) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= {4'd0, evict_q, enc_pkg::SLOT_W'(slot_q), aout_q, hit_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`ENC_ASSERT_IMP(a_ins_no_hit, clk, arst_n, m_tvalid && m_tdata[43], !m_tdata[0])
	`ENC_ASSERT_IMP(a_no_take_busy, clk, arst_n, state_q == ST_CLEAR, !s_tready)
	`ENC_ASSERT_NXT(a_write_then_done, clk, arst_n, state_q == ST_WRITE, state_q == ST_DONE)
endmodule

[dv/tb_expiring_name_cache.sv]
// Self-checking testbench for the expiring name cache: a scoreboard class predicts
// every lookup and insert result and checks the m_tdata words. Depends on enc_pkg and expiring_name_cache.
`timescale 1ns / 100ps

module tb_expiring_name_cache;
	localparam int CYCLE_LIMIT = 6000000;

	typedef struct packed {
		logic                       hit;
		logic [enc_pkg::ADDR_W-1:0] address;
		logic [enc_pkg::SLOT_W-1:0] slot;
		logic                       evicted_live;
	} cache_answer_t;

	// Predicts the cache and holds the answers still owed by the block
	class name_cache_scoreboard;
		logic [enc_pkg::WORD_W-1:0] name_mem [enc_pkg::ENTRIES][enc_pkg::NAME_WORDS];
		logic [enc_pkg::TIME_W-1:0] expiry_mem [enc_pkg::ENTRIES];
		logic [enc_pkg::ADDR_W-1:0] address_mem [enc_pkg::ENTRIES];
		logic [enc_pkg::WORD_W-1:0] name_buf [4];
		logic [enc_pkg::LIFE_W-1:0] lifetime;
		cache_answer_t              owed [$];
		int                         errors;

		function void clear();
			lifetime = enc_pkg::LIFETIME_RESET;
			for (int e = 0; e < enc_pkg::ENTRIES; e++) begin
				expiry_mem[e] = '0;
				address_mem[e] = '0;
				for (int w = 0; w < enc_pkg::NAME_WORDS; w++)
					name_mem[e][w] = '0;
			end
			for (int w = 0; w < 4; w++)
				name_buf[w] = '0;
			owed.delete();
			errors = 0;
		endfunction

		function bit same_name(int e);
			for (int w = 0; w < enc_pkg::NAME_WORDS; w++)
				if (name_mem[e][w] !== name_buf[w])
					return 0;
			return 1;
		endfunction

		// Collect one word; on the last word run the lookup or insert
		function void note_word(logic mode, logic [enc_pkg::WORD_W-1:0] word,
				logic [enc_pkg::WIDX_W-1:0] idx, logic last,
				logic [enc_pkg::TIME_W-1:0] now_s, logic [enc_pkg::ADDR_W-1:0] addr_in);
			cache_answer_t ans;
			bit found;
			logic [enc_pkg::TIME_W:0] sum;
			int e;
			if (idx < enc_pkg::NAME_WORDS)
				name_buf[idx] = word;
			if (!last)
				return;
			ans = '0;
			if (mode == enc_pkg::MODE_LOOKUP) begin
				for (e = 0; e < enc_pkg::ENTRIES; e++) begin
					if (expiry_mem[e] > now_s && same_name(e)) begin
						ans.hit = 1'b1;
						ans.address = address_mem[e];
						ans.slot = e[enc_pkg::SLOT_W-1:0];
						break;
					end
				end
			end else begin
				found = 0;
				for (e = 0; e < enc_pkg::ENTRIES; e++) begin
					if (expiry_mem[e] <= now_s) begin
						found = 1;
						break;
					end
				end
				if (!found) begin
					e = now_s % enc_pkg::ENTRIES;
					ans.evicted_live = 1'b1;
				end
				ans.slot = e[enc_pkg::SLOT_W-1:0];
				for (int w = 0; w < enc_pkg::NAME_WORDS; w++)
					name_mem[e][w] = name_buf[w];
				// saturate the expiry sum
				sum = {1'b0, now_s} + lifetime;
				expiry_mem[e] = sum[enc_pkg::TIME_W] ? '1 : sum[enc_pkg::TIME_W-1:0];
				address_mem[e] = addr_in;
			end
			for (int w = 0; w < 4; w++)
				name_buf[w] = '0;
			owed.push_back(ans);
		endfunction

		task report_mismatch(string what, logic [enc_pkg::ADDR_W-1:0] got,
				logic [enc_pkg::ADDR_W-1:0] want);
			$display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
			errors++;
		endtask

		// Compare one result word with the oldest owed answer
		task check_result(logic [47:0] data);
			cache_answer_t want;
			if (owed.size() == 0) begin
				report_mismatch("unexpected result word", data[31:0], '0);
				return;
			end
			want = owed.pop_front();
			if (data[0] !== want.hit)
				report_mismatch("hit", enc_pkg::ADDR_W'(data[0]),
					enc_pkg::ADDR_W'(want.hit));
			if (data[32:1] !== want.address)
				report_mismatch("address_out", data[32:1], want.address);
			if (data[42:33] !== want.slot)
				report_mismatch("slot", enc_pkg::ADDR_W'(data[42:33]),
					enc_pkg::ADDR_W'(want.slot));
			if (data[43] !== want.evicted_live)
				report_mismatch("evicted_live", enc_pkg::ADDR_W'(data[43]),
					enc_pkg::ADDR_W'(want.evicted_live));
		endtask
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [47:0]  m_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	name_cache_scoreboard sb;
	int unsigned cycle_count;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic [enc_pkg::TIME_W-1:0] clock_s;
	logic [enc_pkg::WORD_W-1:0] pool [12][enc_pkg::NAME_WORDS];
	int pool_len [12];

	expiring_name_cache i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Take result words, stalling at the phase's rate
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Guard against a hung block
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_expiring_name_cache: errors");
			$finish;
		end
	end

	// Present one input word and hold it until accepted
	task send_word(logic mode, logic [enc_pkg::WORD_W-1:0] word,
			logic [enc_pkg::WIDX_W-1:0] idx, logic last,
			logic [enc_pkg::TIME_W-1:0] now_s, logic [enc_pkg::ADDR_W-1:0] addr_in);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tlast <= last;
		s_tdata <= {6'd0, addr_in, now_s, idx, word};
		do @(posedge clk); while (!s_tready);
		sb.note_word(mode, word, idx, last, now_s, addr_in);
	endtask

	// Hold off until every owed result has come, then let the block settle
	task drain();
		s_tvalid <= 1'b0;
		while (sb.owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_lifetime(logic [enc_pkg::LIFE_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.lifetime = value;
	endtask

	// Send a whole name from the pool as a lookup or an insert
	task run_name(logic mode, int p, logic [enc_pkg::TIME_W-1:0] now_s,
			logic [enc_pkg::ADDR_W-1:0] addr_in);
		for (int w = 0; w < pool_len[p]; w++)
			send_word(mode, pool[p][w], enc_pkg::WIDX_W'(w), w == pool_len[p] - 1,
				now_s, addr_in);
	endtask

	task random_phase(int words, logic [enc_pkg::LIFE_W-1:0] life);
		int sent;
		int kind;
		write_lifetime(life);
		sent = 0;
		while (sent < words) begin
			kind = $urandom_range(99);
			clock_s = clock_s + $urandom_range(life / 2 + 2);
			if (kind < 75) begin
				// well-formed name, mostly lookups
				int p;
				p = $urandom_range(11);
				run_name(($urandom_range(99) < 40) ? enc_pkg::MODE_INSERT :
					enc_pkg::MODE_LOOKUP, p, clock_s, $urandom);
				sent += pool_len[p];
			end else if (kind < 90) begin
				// stray word with random fields
				send_word(1'($urandom_range(1)), {$urandom, $urandom},
					enc_pkg::WIDX_W'($urandom_range(3)), 1'($urandom_range(1)),
					($urandom_range(9) == 0) ? $urandom : clock_s, $urandom);
				sent++;
			end else if (kind < 97) begin
				// broken name: words without an end, the next name inherits them
				send_word(enc_pkg::MODE_LOOKUP, {$urandom, $urandom},
					enc_pkg::WIDX_W'($urandom_range(3)), 1'b0, clock_s, $urandom);
				sent++;
			end else begin
				drain();
			end
		end
		s_tvalid <= 1'b0;
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycle_count = 0;
		// name pool: lengths one to four words, one name all ones
		for (int p = 0; p < 12; p++) begin
			pool_len[p] = (p % 4) + 1;
			for (int w = 0; w < enc_pkg::NAME_WORDS; w++)
				pool[p][w] = (w < pool_len[p]) ?
					((p == 11) ? '1 : {$urandom, $urandom}) : '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty miss, insert and hit, expiry edge, saturation, duplicates
		clock_s = 100;
		run_name(enc_pkg::MODE_LOOKUP, 0, clock_s, '0);
		run_name(enc_pkg::MODE_INSERT, 0, clock_s, 32'hFFFF_FFFF);
		run_name(enc_pkg::MODE_LOOKUP, 0, clock_s, '0);
		run_name(enc_pkg::MODE_LOOKUP, 0, clock_s + 899, '0);
		run_name(enc_pkg::MODE_LOOKUP, 0, clock_s + 900, '0);
		run_name(enc_pkg::MODE_INSERT, 11, 32'd0, 32'h0000_0000);
		run_name(enc_pkg::MODE_LOOKUP, 11, 32'd0, '0);
		run_name(enc_pkg::MODE_INSERT, 1, clock_s, 32'h1234_5678);
		run_name(enc_pkg::MODE_INSERT, 1, clock_s, 32'h8765_4321);
		run_name(enc_pkg::MODE_LOOKUP, 1, clock_s + 1, '0);
		write_lifetime(16'hFFFF);
		run_name(enc_pkg::MODE_INSERT, 2, 32'hFFFF_FF00, 32'hA5A5_5A5A);
		run_name(enc_pkg::MODE_LOOKUP, 2, 32'hFFFF_FFFE, '0);
		write_lifetime(16'd1);
		run_name(enc_pkg::MODE_INSERT, 3, 32'd500, 32'h0BAD_F00D);
		run_name(enc_pkg::MODE_LOOKUP, 3, 32'd500, '0);
		run_name(enc_pkg::MODE_LOOKUP, 3, 32'd501, '0);
		drain();

		// Random phases under several idle patterns
		clock_s = 32'd6000000;
		send_idle_pct = 0;  recv_stall_pct = 0;
		random_phase(135, 16'd30);
		send_idle_pct = 77; recv_stall_pct = 0;
		random_phase(130, 16'd900);
		send_idle_pct = 0;  recv_stall_pct = 77;
		random_phase(130, 16'd1);
		send_idle_pct = 10; recv_stall_pct = 10;
		random_phase(135, 16'd65535);

		drain();
		repeat (1100) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0)
			$display("tb_expiring_name_cache: clean");
		else
			$display("tb_expiring_name_cache: errors");
		$finish;
	end
endmodule

[expiring_name_cache.f]
+incdir+rtl
rtl/enc_pkg.sv
rtl/enc_cell.sv
rtl/expiring_name_cache.sv
dv/tb_expiring_name_cache.sv
